### sv/vtv_pkg.sv
package vtv_pkg;

    localparam logic OP_XFORM = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    localparam logic [1:0] SEL_MODEL = 2'd0;
    localparam logic [1:0] SEL_VIEW  = 2'd1;
    localparam logic [1:0] SEL_PROJ  = 2'd2;

    localparam logic [1:0] KIND_WORLD  = 2'd0;
    localparam logic [1:0] KIND_CLIP   = 2'd1;
    localparam logic [1:0] KIND_NORMAL = 2'd2;
    localparam logic [1:0] KIND_SCREEN = 2'd3;

    localparam logic CFG_VP_WIDTH  = 1'b0;
    localparam logic CFG_VP_HEIGHT = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // fixed latencies of the square root and divider pipelines
    localparam int SQRT_LAT = 32;
    localparam int DIV_LAT  = 33;

    typedef enum logic {
        CMD_XFORM,
        CMD_LOAD
    } cmd_t;

    typedef struct packed {
        logic              op;
        logic [1:0]        matrix_select;
        logic [3:0]        entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] val_a;
        logic signed [31:0] val_b;
        logic signed [31:0] val_c;
        logic signed [31:0] val_d;
        logic               last;
    } out_item_t;

    typedef struct packed {
        cmd_t     cmd;
        in_item_t item;
    } qentry_t;

endpackage

### sv/vertex_transform_viewport.sv
// A transform leaves as four results (world, clip, normal, screen), the
// screen one marked last. Throughput: loads one per cycle, but a load
// waits for transforms in the first five datapath stages to clear.
// Transforms enter while earlier ones are in flight; the pipeline stalls
// when a finished transform meets a busy result port. Reset clears control
// state and sets the viewport to 640x480; the matrix store is not cleared.
module vertex_transform_viewport #(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vtv_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vtv_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data
);

    logic [12:0]      vp_w_reg;
    logic [12:0]      vp_h_reg;
    logic             q_valid;
    logic             q_pop;
    vtv_pkg::qentry_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg <= 13'd640;
            vp_h_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vtv_pkg::CFG_VP_WIDTH:  vp_w_reg <= cfg_data;
                vtv_pkg::CFG_VP_HEIGHT: vp_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vtv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    vtv_back #(.FRAC_BITS(FRAC_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .vp_w      (vp_w_reg),
        .vp_h      (vp_h_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sv/vtv_front.sv
module vtv_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vtv_pkg::in_item_t in_data,
    output logic              q_valid,
    output vtv_pkg::qentry_t  q_entry,
    input  logic              q_pop
);

    vtv_pkg::qentry_t            qmem_reg [0:vtv_pkg::QDEPTH-1];
    logic [vtv_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [vtv_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [vtv_pkg::QPTR_W:0]    cnt_reg, cnt_next;
    logic                        accept;
    logic                        push;
    vtv_pkg::cmd_t               cmd;
    logic                        keep;

    assign in_ready = (cnt_reg != (vtv_pkg::QPTR_W + 1)'(vtv_pkg::QDEPTH));
    assign accept   = in_valid && in_ready;

    // classify: loads to a nonexistent matrix are dropped here
    always_comb
    begin
        cmd  = vtv_pkg::CMD_XFORM;
        keep = 1'b1;
        unique case (in_data.op)
            vtv_pkg::OP_LOAD:
            begin
                cmd  = vtv_pkg::CMD_LOAD;
                keep = (in_data.matrix_select == vtv_pkg::SEL_MODEL) ||
                       (in_data.matrix_select == vtv_pkg::SEL_VIEW) ||
                       (in_data.matrix_select == vtv_pkg::SEL_PROJ);
            end
            default:
            begin
                cmd  = vtv_pkg::CMD_XFORM;
                keep = 1'b1;
            end
        endcase
    end

    assign push    = accept && keep;
    assign q_valid = (cnt_reg != '0);
    assign q_entry = qmem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem_reg[wr_ptr_reg] <= '{cmd: cmd, item: in_data};
        end
    end

endmodule

### sv/vtv_delay.sv
module vtv_delay #(
    parameter int W = 32,
    parameter int N = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] d_reg [0:N-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                d_reg[i] <= d_reg[i-1];
            end
        end
    end

    assign dout = d_reg[N-1];

endmodule

### sv/vtv_isqrt.sv
module vtv_isqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] val,
    output logic [31:0] root
);

    // one result bit per stage, two radicand bits consumed per stage
    logic [33:0] rem_reg  [0:30];
    logic [63:0] v_reg    [0:30];
    logic [31:0] root_reg [0:31];

    for (genvar s = 0; s < 32; s++)
    begin : g_stage
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] v_in;
        logic [35:0] cand;
        logic [35:0] trial;
        logic        ge;

        if (s == 0)
        begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = val;
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        assign cand  = {rem_in, v_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cand >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= {root_in[30:0], ge};
            end
        end

        if (s < 31)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? 34'(cand - trial) : cand[33:0];
                    v_reg[s]   <= {v_in[61:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[31];

endmodule

### sv/vtv_div.sv
module vtv_div #(
    parameter int NUM_W = 48
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [31:0]       den,
    input  logic              neg,
    output logic signed [31:0] quo
);

    // stage 0 checks for a quotient of 2^31 or more (saturates), stages
    // 1..31 produce one quotient bit each, last register applies the sign
    logic [31:0] rem_reg [0:30];
    logic [30:0] low_reg [0:30];
    logic [31:0] den_reg [0:30];
    logic [30:0] q_reg   [0:31];
    logic        ovf_reg [0:31];
    logic        neg_reg [0:31];
    logic signed [31:0] quo_reg;
    logic [31:0] hi;

    assign hi = 32'(num >> 31);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi;
            low_reg[0] <= num[30:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (hi >= den);
            neg_reg[0] <= neg;
        end
    end

    for (genvar s = 1; s < 32; s++)
    begin : g_stage
        logic [32:0] cand;
        logic        ge;

        assign cand = {rem_reg[s-1], low_reg[s-1][30]};
        assign ge   = (cand >= {1'b0, den_reg[s-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s]   <= {q_reg[s-1][29:0], ge};
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end

        if (s < 31)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= ge ? 32'(cand - {1'b0, den_reg[s-1]}) : cand[31:0];
                    low_reg[s] <= {low_reg[s-1][29:0], 1'b0};
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[31])
            begin
                quo_reg <= neg_reg[31] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
            else if (neg_reg[31])
            begin
                quo_reg <= -$signed({1'b0, q_reg[31]});
            end
            else
            begin
                quo_reg <= $signed({1'b0, q_reg[31]});
            end
        end
    end

    assign quo = quo_reg;

endmodule

### sv/vtv_back.sv
module vtv_back #(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  vtv_pkg::qentry_t   q_entry,
    output logic               q_pop,
    input  logic [12:0]        vp_w,
    input  logic [12:0]        vp_h,
    output logic               out_valid,
    input  logic               out_ready,
    output vtv_pkg::out_item_t out_data
);

    localparam int NUM_W   = 32 + FRAC_BITS;
    localparam int ST_WORLD = 2;
    localparam int ST_SUMSQ = 4;
    localparam int ST_CLIP  = 6;
    localparam int ST_ROOT  = ST_SUMSQ + vtv_pkg::SQRT_LAT;
    localparam int ST_NDC   = ST_CLIP + vtv_pkg::DIV_LAT;
    localparam int ST_SCR   = ST_NDC + 2;
    localparam int TAIL     = ST_ROOT + vtv_pkg::DIV_LAT;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
    localparam logic signed [32:0] ONE33  = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] ONE32  = 32'sd1 <<< FRAC_BITS;

    function automatic logic signed [31:0] fold4(
        input logic signed [63:0] a,
        input logic signed [63:0] b,
        input logic signed [63:0] c,
        input logic signed [63:0] d
    );
        logic signed [65:0] s;
        s = (66'(a) + 66'(b) + 66'(c) + 66'(d)) >>> FRAC_BITS;
        if (s > SAT_HI)
        begin
            return 32'sh7fff_ffff;
        end
        if (s < SAT_LO)
        begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    // matrix banks; the model matrix's upper 3x3 feeds both position and normal multipliers
    logic signed [31:0] mdl_reg [0:15];
    logic signed [31:0] viw_reg [0:15];
    logic signed [31:0] prj_reg [0:15];

    logic vld_reg [0:TAIL];
    logic adv;
    logic issue;
    logic do_load;
    logic front_busy;

    logic signed [31:0] pos_reg  [0:2];
    logic signed [31:0] nin_reg  [0:2];
    logic signed [63:0] wp_reg   [0:3][0:2];
    logic signed [63:0] np_reg   [0:2][0:2];
    logic signed [31:0] world_reg [0:3];
    logic signed [31:0] nw_reg   [0:2];
    logic signed [63:0] vp_reg   [0:3][0:3];
    logic signed [63:0] sq_reg   [0:2];
    logic signed [31:0] view_reg [0:3];
    logic [63:0]        sumsq_reg;
    logic signed [63:0] cp_reg   [0:3][0:3];
    logic signed [31:0] clip_reg [0:3];

    // serializer
    logic        ser_busy_reg, ser_busy_next;
    logic [1:0]  ser_cnt_reg, ser_cnt_next;
    logic        ser_free;
    logic        ser_load;
    logic [95:0]  sw_reg;
    logic [127:0] sc_reg;
    logic [95:0]  sn_reg;
    logic [127:0] ss_reg;

    assign front_busy = vld_reg[0] || vld_reg[1] || vld_reg[2] || vld_reg[3] || vld_reg[4];
    assign ser_free   = !ser_busy_reg || (out_ready && ser_cnt_reg == vtv_pkg::KIND_SCREEN);
    assign adv        = !vld_reg[TAIL] || ser_free;
    assign ser_load   = adv && vld_reg[TAIL];

    // loads wait until no transform still has to read a matrix
    assign issue   = q_valid && (q_entry.cmd == vtv_pkg::CMD_XFORM) && adv;
    assign do_load = q_valid && (q_entry.cmd == vtv_pkg::CMD_LOAD) && !front_busy;
    assign q_pop   = issue || do_load;

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            unique case (q_entry.item.matrix_select)
                vtv_pkg::SEL_MODEL: mdl_reg[q_entry.item.entry_index] <= q_entry.item.entry_value;
                vtv_pkg::SEL_VIEW:  viw_reg[q_entry.item.entry_index] <= q_entry.item.entry_value;
                vtv_pkg::SEL_PROJ:  prj_reg[q_entry.item.entry_index] <= q_entry.item.entry_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TAIL; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= issue;
            for (int i = 1; i <= TAIL; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // front half of the datapath: three matrix passes, the normal row sums and their sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg[0] <= q_entry.item.pos_x;
            pos_reg[1] <= q_entry.item.pos_y;
            pos_reg[2] <= q_entry.item.pos_z;
            nin_reg[0] <= q_entry.item.norm_x;
            nin_reg[1] <= q_entry.item.norm_y;
            nin_reg[2] <= q_entry.item.norm_z;

            for (int r = 0; r < 4; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    wp_reg[r][k] <= 64'(mdl_reg[r*4+k]) * 64'(pos_reg[k]);
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    np_reg[r][k] <= 64'(mdl_reg[r*4+k]) * 64'(nin_reg[k]);
                end
            end

            for (int r = 0; r < 4; r++)
            begin
                world_reg[r] <= fold4(wp_reg[r][0], wp_reg[r][1], wp_reg[r][2],
                                      64'(mdl_reg[r*4+3]) <<< FRAC_BITS);
            end
            for (int r = 0; r < 3; r++)
            begin
                nw_reg[r] <= fold4(np_reg[r][0], np_reg[r][1], np_reg[r][2], 64'sd0);
            end

            for (int r = 0; r < 4; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    vp_reg[r][k] <= 64'(viw_reg[r*4+k]) * 64'(world_reg[k]);
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                sq_reg[r] <= 64'(nw_reg[r]) * 64'(nw_reg[r]);
            end

            for (int r = 0; r < 4; r++)
            begin
                view_reg[r] <= fold4(vp_reg[r][0], vp_reg[r][1], vp_reg[r][2], vp_reg[r][3]);
            end
            sumsq_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);

            for (int r = 0; r < 4; r++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    cp_reg[r][k] <= 64'(prj_reg[r*4+k]) * 64'(view_reg[k]);
                end
            end

            for (int r = 0; r < 4; r++)
            begin
                clip_reg[r] <= fold4(cp_reg[r][0], cp_reg[r][1], cp_reg[r][2], cp_reg[r][3]);
            end
        end
    end

    // normal length and normalize
    logic [31:0]  len_root;
    logic [95:0]  nw_d;
    logic         lzero_d;
    logic signed [31:0] nq [0:2];

    vtv_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (adv),
        .val  (sumsq_reg),
        .root (len_root)
    );

    vtv_delay #(.W(96), .N(ST_ROOT - ST_WORLD)) u_dly_nw
    (
        .clk  (clk),
        .en   (adv),
        .din  ({nw_reg[0], nw_reg[1], nw_reg[2]}),
        .dout (nw_d)
    );

    vtv_delay #(.W(1), .N(vtv_pkg::DIV_LAT)) u_dly_lz
    (
        .clk  (clk),
        .en   (adv),
        .din  (len_root == '0),
        .dout (lzero_d)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_ndiv
        logic signed [31:0] c;
        assign c = nw_d[95-32*i -: 32];
        vtv_div #(.NUM_W(NUM_W)) u_div
        (
            .clk (clk),
            .en  (adv),
            .num (NUM_W'(mag(c)) << FRAC_BITS),
            .den (len_root),
            .neg (c[31]),
            .quo (nq[i])
        );
    end

    // perspective divide and 1/w
    logic signed [31:0] pq [0:3];

    for (genvar i = 0; i < 3; i++)
    begin : g_pdiv
        vtv_div #(.NUM_W(NUM_W)) u_div
        (
            .clk (clk),
            .en  (adv),
            .num (NUM_W'(mag(clip_reg[i])) << FRAC_BITS),
            .den (mag(clip_reg[3])),
            .neg (clip_reg[i][31] ^ clip_reg[3][31]),
            .quo (pq[i])
        );
    end

    vtv_div #(.NUM_W(NUM_W)) u_div_invw
    (
        .clk (clk),
        .en  (adv),
        .num (NUM_W'(1) << (2 * FRAC_BITS)),
        .den (mag(clip_reg[3])),
        .neg (clip_reg[3][31]),
        .quo (pq[3])
    );

    logic [127:0] clip_ndc;
    logic [127:0] clip_tail;
    logic [95:0]  world_tail;
    logic [127:0] scr_tail;

    vtv_delay #(.W(128), .N(ST_NDC - ST_CLIP)) u_dly_clip_a
    (
        .clk  (clk),
        .en   (adv),
        .din  ({clip_reg[0], clip_reg[1], clip_reg[2], clip_reg[3]}),
        .dout (clip_ndc)
    );

    vtv_delay #(.W(128), .N(TAIL - ST_NDC)) u_dly_clip_b
    (
        .clk  (clk),
        .en   (adv),
        .din  (clip_ndc),
        .dout (clip_tail)
    );

    vtv_delay #(.W(96), .N(TAIL - ST_WORLD)) u_dly_world
    (
        .clk  (clk),
        .en   (adv),
        .din  ({world_reg[0], world_reg[1], world_reg[2]}),
        .dout (world_tail)
    );

    // viewport mapping
    logic               w_zero;
    logic signed [31:0] ndc [0:2];
    logic signed [46:0] px_reg;
    logic signed [46:0] py_reg;
    logic signed [32:0] pz_reg;
    logic signed [31:0] invw40_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg, invw41_reg;
    logic signed [46:0] sx_t, sy_t, hix, hiy;
    logic signed [32:0] sz_t;

    assign w_zero = (clip_ndc[31:0] == '0);
    assign ndc[0] = w_zero ? $signed(clip_ndc[127:96]) : pq[0];
    assign ndc[1] = w_zero ? $signed(clip_ndc[95:64])  : pq[1];
    assign ndc[2] = w_zero ? $signed(clip_ndc[63:32])  : pq[2];

    always_comb
    begin
        hix  = (47'($signed({1'b0, vp_w})) - 47'sd1) <<< FRAC_BITS;
        hiy  = (47'($signed({1'b0, vp_h})) - 47'sd1) <<< FRAC_BITS;
        sx_t = px_reg >>> 1;
        sy_t = py_reg >>> 1;
        sz_t = pz_reg >>> 1;
        if (sx_t > hix)
        begin
            sx_t = hix;
        end
        if (sx_t < 0)
        begin
            sx_t = '0;
        end
        if (sy_t > hiy)
        begin
            sy_t = hiy;
        end
        if (sy_t < 0)
        begin
            sy_t = '0;
        end
        if (sz_t > ONE33)
        begin
            sz_t = ONE33;
        end
        if (sz_t < 0)
        begin
            sz_t = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg     <= 47'(33'(ndc[0]) + ONE33) * 47'($signed({1'b0, vp_w}));
            py_reg     <= 47'(ONE33 - 33'(ndc[1])) * 47'($signed({1'b0, vp_h}));
            pz_reg     <= 33'(ndc[2]) + ONE33;
            invw40_reg <= w_zero ? ONE32 : pq[3];
            sx_reg     <= sx_t[31:0];
            sy_reg     <= sy_t[31:0];
            sz_reg     <= sz_t[31:0];
            invw41_reg <= invw40_reg;
        end
    end

    vtv_delay #(.W(128), .N(TAIL - ST_SCR)) u_dly_scr
    (
        .clk  (clk),
        .en   (adv),
        .din  ({sx_reg, sy_reg, sz_reg, invw41_reg}),
        .dout (scr_tail)
    );

    // result serializer: one transaction per result kind
    always_comb
    begin
        ser_busy_next = ser_busy_reg;
        ser_cnt_next  = ser_cnt_reg;
        if (ser_load)
        begin
            ser_busy_next = 1'b1;
            ser_cnt_next  = vtv_pkg::KIND_WORLD;
        end
        else if (ser_busy_reg && out_ready)
        begin
            if (ser_cnt_reg == vtv_pkg::KIND_SCREEN)
            begin
                ser_busy_next = 1'b0;
            end
            else
            begin
                ser_cnt_next = ser_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_busy_reg <= 1'b0;
            ser_cnt_reg  <= vtv_pkg::KIND_WORLD;
        end
        else
        begin
            ser_busy_reg <= ser_busy_next;
            ser_cnt_reg  <= ser_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            sw_reg <= world_tail;
            sc_reg <= clip_tail;
            sn_reg <= lzero_d ? 96'd0 : {nq[0], nq[1], nq[2]};
            ss_reg <= scr_tail;
        end
    end

    assign out_valid = ser_busy_reg;

    always_comb
    begin
        out_data.kind = ser_cnt_reg;
        out_data.last = 1'b0;
        case (ser_cnt_reg)
            vtv_pkg::KIND_WORLD:
            begin
                out_data.val_a = sw_reg[95:64];
                out_data.val_b = sw_reg[63:32];
                out_data.val_c = sw_reg[31:0];
                out_data.val_d = '0;
            end
            vtv_pkg::KIND_CLIP:
            begin
                out_data.val_a = sc_reg[127:96];
                out_data.val_b = sc_reg[95:64];
                out_data.val_c = sc_reg[63:32];
                out_data.val_d = sc_reg[31:0];
            end
            vtv_pkg::KIND_NORMAL:
            begin
                out_data.val_a = sn_reg[95:64];
                out_data.val_b = sn_reg[63:32];
                out_data.val_c = sn_reg[31:0];
                out_data.val_d = '0;
            end
            default:
            begin
                out_data.val_a = ss_reg[127:96];
                out_data.val_b = ss_reg[95:64];
                out_data.val_c = ss_reg[63:32];
                out_data.val_d = ss_reg[31:0];
                out_data.last  = 1'b1;
            end
        endcase
    end

endmodule
